FILE: rtl/tbpsd_pkg.sv
// Shared types and constants for the two-button pin-scan debouncer.
// No dependencies; imported by every module of the block.
package tbpsd_pkg;

   localparam int HIST_BITS  = 2;
   localparam int HIST_DEPTH = 1 << HIST_BITS;

   localparam int CFG_WIDTH  = 16;
   localparam int ADDR_WIDTH = 2;
   localparam int REQ_WIDTH  = 8;
   localparam int RSP_WIDTH  = 8;

   // register indexes
   localparam logic [ADDR_WIDTH-1:0] REG_SCAN_PERIOD     = 2'd0;
   localparam logic [ADDR_WIDTH-1:0] REG_DISCHARGE_TICKS = 2'd1;
   localparam logic [ADDR_WIDTH-1:0] REG_CHARGE_TICKS    = 2'd2;

   localparam logic [CFG_WIDTH-1:0] SCAN_PERIOD_RST     = 16'd100;
   localparam logic [CFG_WIDTH-1:0] DISCHARGE_TICKS_RST = 16'd10;
   localparam logic [CFG_WIDTH-1:0] CHARGE_TICKS_RST    = 16'd10;
   localparam logic [CFG_WIDTH-1:0] COUNT_MAX           = 16'hFFFF;

   // scan classes / debounced directions
   typedef logic [1:0] class_type;
   localparam class_type CLS_NONE = 2'd0;
   localparam class_type CLS_POS  = 2'd1;
   localparam class_type CLS_NEG  = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'b001,
      PH_DISCHARGE = 3'b010,
      PH_CHARGE    = 3'b100
   } phase_type;

   // one classified scan, sequencer to history
   typedef struct packed {
      logic      valid;
      class_type cls;
   } scan_event_type;

endpackage

FILE: rtl/tbpsd_scan_seq.sv
// Scan sequencer: wait counter, discharge/charge phases, pin classification.
// Depends on tbpsd_pkg.
module tbpsd_scan_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          pin_level,
   input  logic [tbpsd_pkg::CFG_WIDTH-1:0] scan_period,
   input  logic [tbpsd_pkg::CFG_WIDTH-1:0] discharge_ticks,
   input  logic [tbpsd_pkg::CFG_WIDTH-1:0] charge_ticks,
   output tbpsd_pkg::scan_event_type     scan_event,
   output logic                          drive_low_in
);
   import tbpsd_pkg::*;

   logic [CFG_WIDTH-1:0] wait_ff, wait_in;
   logic [CFG_WIDTH-1:0] count_ff, count_in;
   phase_type            phase_ff, phase_in;
   logic                 first_ff, first_in;
   logic                 started;

   always_comb begin
      wait_in    = wait_ff;
      count_in   = count_ff;
      phase_in   = phase_ff;
      first_in   = first_ff;
      started    = 1'b0;
      scan_event = '{valid: 1'b0, cls: CLS_NONE};
      case (phase_ff)
         PH_DISCHARGE: begin
            if (count_ff == '0) begin
               phase_in = PH_CHARGE;
               count_in = charge_ticks;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         PH_CHARGE: begin
            if (count_ff == '0) begin
               scan_event.valid = 1'b1;
               if (pin_level)
                  scan_event.cls = CLS_NONE;
               else if (!first_ff)
                  scan_event.cls = CLS_POS;
               else
                  scan_event.cls = CLS_NEG;
               phase_in = PH_IDLE;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (wait_ff >= scan_period) begin
               first_in = pin_level;
               wait_in  = '0;
               phase_in = PH_DISCHARGE;
               count_in = discharge_ticks;
               started  = 1'b1;
            end
         end
      endcase
      if (!started && wait_ff != COUNT_MAX)
         wait_in = wait_ff + 1'b1;
      drive_low_in = (phase_in == PH_DISCHARGE);
      scan_event.valid = scan_event.valid & step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff  <= '0;
         count_ff <= '0;
         phase_ff <= PH_IDLE;
         first_ff <= 1'b0;
      end else if (step) begin
         wait_ff  <= wait_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         first_ff <= first_in;
      end
   end

endmodule

FILE: rtl/tbpsd_history.sv
// Circular class history and all-equal compare giving the debounced direction.
// Depends on tbpsd_pkg.
module tbpsd_history (
   input  logic                       clock,
   input  logic                       reset,
   input  tbpsd_pkg::scan_event_type  scan_event,
   output tbpsd_pkg::class_type       direction_in
);
   import tbpsd_pkg::*;

   class_type            hist_ff [HIST_DEPTH];
   class_type            hist_in [HIST_DEPTH];
   logic [HIST_BITS-1:0] index_ff, index_in;
   class_type            stable_ff;
   logic                 same;

   always_comb begin
      index_in = index_ff + 1'b1;
      same     = 1'b1;
      for (int i = 0; i < HIST_DEPTH; i++)
         hist_in[i] = (index_in == HIST_BITS'(i)) ? scan_event.cls : hist_ff[i];
      for (int i = 1; i < HIST_DEPTH; i++)
         if (hist_in[i] != hist_in[0])
            same = 1'b0;
      direction_in = (scan_event.valid && same) ? hist_in[0] : stable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++)
            hist_ff[i] <= CLS_NONE;
         index_ff  <= '0;
         stable_ff <= CLS_NONE;
      end else if (scan_event.valid) begin
         hist_ff   <= hist_in;
         index_ff  <= index_in;
         stable_ff <= direction_in;
      end
   end

endmodule

FILE: rtl/two_button_pin_scan_debouncer.sv
// Two-button pin-scan debouncer, top level: config registers, output register.
// Each accepted tick's result item is registered in the output register and shown on rsp_tdata.
// Throughput: one tick per cycle; req_tready stays high while the output
// register is empty or being drained, so ticks stream back to back.
// Reset (synchronous, active high): registers to 100/10/10, idle phase,
// history all none, direction none, output register empty.
module two_button_pin_scan_debouncer (
   input  logic                            clock,
   input  logic                            reset,
   // config write port
   input  logic                            csr_we,
   input  logic [tbpsd_pkg::ADDR_WIDTH-1:0] csr_addr,
   input  logic [tbpsd_pkg::CFG_WIDTH-1:0]  csr_wdata,
   // tick input
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tbpsd_pkg::REQ_WIDTH-1:0]  req_tdata,  // [0] pin_level, [7:1] zero
   // result output
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tbpsd_pkg::RSP_WIDTH-1:0]  rsp_tdata   // [0] pin_drive_low,
                                                        // [2:1] direction,
                                                        // [3] scan_done, [7:4] zero
);
   import tbpsd_pkg::*;

   logic [CFG_WIDTH-1:0] scan_period_ff, discharge_ff, charge_ff;
   logic                 step;
   logic                 drive_low_in;
   class_type            direction_in;
   scan_event_type       scan_event;
   logic                 rsp_valid_ff;
   logic [RSP_WIDTH-1:0] rsp_data_ff;

   // config registers; unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_period_ff <= SCAN_PERIOD_RST;
         discharge_ff   <= DISCHARGE_TICKS_RST;
         charge_ff      <= CHARGE_TICKS_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SCAN_PERIOD:     scan_period_ff <= csr_wdata;
            REG_DISCHARGE_TICKS: discharge_ff   <= csr_wdata;
            REG_CHARGE_TICKS:    charge_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // take a tick whenever the output slot is free or draining this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   tbpsd_scan_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .pin_level       (req_tdata[0]),
      .scan_period     (scan_period_ff),
      .discharge_ticks (discharge_ff),
      .charge_ticks    (charge_ff),
      .scan_event      (scan_event),
      .drive_low_in    (drive_low_in)
   );

   tbpsd_history u_hist (
      .clock        (clock),
      .reset        (reset),
      .scan_event   (scan_event),
      .direction_in (direction_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step)
         rsp_data_ff <= {4'b0000, scan_event.valid, direction_in, drive_low_in};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: verif/testbench.sv
// Self-checking bench for the two-button pin-scan debouncer: stream driver, monitor,
// scan predictor and register writer in one top module.
// Depends on rtl/tbpsd_pkg.sv and rtl/two_button_pin_scan_debouncer.sv.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tbpsd_pkg::*;

   // cycles with no handshake at all before the run is declared hung
   localparam int IDLE_LIMIT = 2000;
   // index with no register behind it; writes to it must be ignored
   localparam logic [ADDR_WIDTH-1:0] REG_UNUSED = 2'd3;

   // how the generator drives the shared pin for a stretch of ticks
   typedef enum logic [1:0] {
      PIN_RELEASED,   // no button: pin pulled high, scans read none
      PIN_DIRECT,     // button to ground: both samples low, positive
      PIN_CAPACITOR,  // button through the cap: high at start, low later, negative
      PIN_NOISE       // bouncing contact: any level on any tick
   } button_mode_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] period;
      logic [CFG_WIDTH-1:0] discharge;
      logic [CFG_WIDTH-1:0] charge;
   } scan_cfg_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0]       wait_cnt;
      phase_type                  phase;
      logic [CFG_WIDTH-1:0]       phase_cnt;
      logic                       first_level;
      class_type [HIST_DEPTH-1:0] hist;
      logic [HIST_BITS-1:0]       hist_ptr;
      class_type                  stable;
   } scan_state_type;

   // result item fields, lowest bit last
   typedef struct packed {
      logic      scan_done;
      class_type direction;
      logic      drive_low;
   } scan_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [ADDR_WIDTH-1:0] csr_addr = '0;
   logic [CFG_WIDTH-1:0]  csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_WIDTH-1:0]  req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_WIDTH-1:0]  rsp_tdata;

   two_button_pin_scan_debouncer u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [0] pin_level, [7:1] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [0] pin_drive_low, [2:1] direction, [3] scan_done,
                                 // [7:4] zero
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   scan_cfg_type    cfg;            // shadow of the three registers
   scan_state_type  model_state;    // predictor copy, advanced at each accepted item
   scan_state_type  gen_state;      // generator copy, advanced as items are queued
   logic            tick_queue[$];  // pin levels waiting to be driven
   scan_result_type result_queue[$];// predicted result items, oldest first
   logic            req_hold = 1'b0;// an item sits on the req bus, not yet taken
   int              gap_pct = 38;   // idle/stall chance per cycle on both sides
   int              errors = 0;
   int              ticks_taken = 0;
   int              results_seen = 0;
   int              scans_done = 0;
   int              reg_writes = 0;
   int              dir_seen[3] = '{0, 0, 0};
   int              quiet_cycles = 0;

   function automatic scan_state_type idle_state();
      scan_state_type st;
      st.wait_cnt    = '0;
      st.phase       = PH_IDLE;
      st.phase_cnt   = '0;
      st.first_level = 1'b0;
      st.hist        = '0;
      st.hist_ptr    = '0;
      st.stable      = CLS_NONE;
      return st;
   endfunction

   // One timebase tick of the scan sequencer, history and debounce.
   task automatic advance_scan(inout scan_state_type st, input logic level,
                               output scan_result_type res);
      logic      started;
      logic      agree;
      class_type cls;
      int        i;
      started       = 1'b0;
      res.scan_done = 1'b0;
      case (st.phase)
         PH_DISCHARGE: begin
            if (st.phase_cnt == 0) begin
               st.phase     = PH_CHARGE;
               st.phase_cnt = cfg.charge;
            end else begin
               st.phase_cnt = st.phase_cnt - 1'b1;
            end
         end
         PH_CHARGE: begin
            if (st.phase_cnt == 0) begin
               // second sample: high means no button, low means one of the two
               if (level)
                  cls = CLS_NONE;
               else if (!st.first_level)
                  cls = CLS_POS;
               else
                  cls = CLS_NEG;
               // pointer moves first, then the entry at the new pointer is written
               st.hist_ptr          = st.hist_ptr + 1'b1;
               st.hist[st.hist_ptr] = cls;
               agree = 1'b1;
               for (i = 1; i < HIST_DEPTH; i++)
                  if (st.hist[i] != st.hist[0])
                     agree = 1'b0;
               if (agree)
                  st.stable = st.hist[0];
               res.scan_done = 1'b1;
               st.phase      = PH_IDLE;
            end else begin
               st.phase_cnt = st.phase_cnt - 1'b1;
            end
         end
         default: begin
            st.phase = PH_IDLE;
            if (st.wait_cnt >= cfg.period) begin
               st.first_level = level;
               st.wait_cnt    = '0;
               st.phase       = PH_DISCHARGE;
               st.phase_cnt   = cfg.discharge;
               started        = 1'b1;
            end
         end
      endcase
      // wait counter runs through scans too and sticks at all ones
      if (!started && st.wait_cnt != COUNT_MAX)
         st.wait_cnt = st.wait_cnt + 1'b1;
      res.drive_low = (st.phase == PH_DISCHARGE);
      res.direction = st.stable;
   endtask

   // Queue count ticks of one button behavior. The generator tracks the scan
   // phase itself so the capacitor button reads high in the idle phase, where each scan starts.
   task automatic queue_ticks(input button_mode_type mode, input int count,
                              input int flip_pct);
      logic            level;
      scan_result_type unused;
      int              k;
      for (k = 0; k < count; k++) begin
         case (mode)
            PIN_RELEASED:  level = 1'b1;
            PIN_DIRECT:    level = 1'b0;
            PIN_CAPACITOR: level = (gen_state.phase == PH_IDLE);
            default:       level = 1'($urandom_range(1));
         endcase
         if (mode != PIN_NOISE && $urandom_range(99) < flip_pct)
            level = ~level;
         advance_scan(gen_state, level, unused);
         tick_queue.push_back(level);
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR %0t ns: result %0d %s: got %0d, want %0d",
               $time, results_seen, what, got, want);
      errors++;
   endtask

   // Block is idle once every queued item went in and every result came out.
   task automatic drain();
      while (tick_queue.size() != 0 || req_hold || result_queue.size() != 0)
         @(posedge clock);
   endtask

   // One register write, taken at the next rising edge.
   task automatic write_reg(input logic [ADDR_WIDTH-1:0] idx,
                            input logic [CFG_WIDTH-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         REG_SCAN_PERIOD:     cfg.period    = value;
         REG_DISCHARGE_TICKS: cfg.discharge = value;
         REG_CHARGE_TICKS:    cfg.charge    = value;
         default: ;  // no register here
      endcase
      reg_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Driver: everything changes on the falling edge. An item stays on the
   // bus until taken; a new one is only chosen once the old one went in.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         rsp_tready <= ($urandom_range(99) >= gap_pct);
         if (!req_hold) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
               req_tdata  <= {{(REQ_WIDTH-1){1'b0}}, tick_queue.pop_front()};
               req_tvalid <= 1'b1;
               req_hold    = 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: samples both handshakes on the rising edge. Results are
   // checked before the new prediction is queued; the result is registered, so
   // an item's own result can never show up on the edge that takes it.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      scan_result_type got;
      scan_result_type want;
      scan_result_type res;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[3:0];
            if (result_queue.size() == 0) begin
               report_mismatch("arrived with nothing expected", rsp_tdata, 0);
            end else begin
               want = result_queue.pop_front();
               if (got.drive_low !== want.drive_low)
                  report_mismatch("pin_drive_low", got.drive_low, want.drive_low);
               if (got.direction !== want.direction)
                  report_mismatch("direction", got.direction, want.direction);
               if (got.scan_done !== want.scan_done)
                  report_mismatch("scan_done", got.scan_done, want.scan_done);
               if (rsp_tdata[RSP_WIDTH-1:4] !== '0)
                  report_mismatch("padding", rsp_tdata[RSP_WIDTH-1:4], 0);
               if (want.direction < 3)
                  dir_seen[want.direction]++;
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            advance_scan(model_state, req_tdata[0], res);
            result_queue.push_back(res);
            if (res.scan_done)
               scans_done++;
            ticks_taken++;
            req_hold = 1'b0;
         end
      end
   end

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus sequence
   // ---------------------------------------------------------------------
   initial begin
      int random_ticks;
      int round;
      int n;
      int seg;
      int pick;
      button_mode_type mode;

      cfg.period    = SCAN_PERIOD_RST;
      cfg.discharge = DISCHARGE_TICKS_RST;
      cfg.charge    = CHARGE_TICKS_RST;
      model_state   = idle_state();
      gen_state     = idle_state();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // -- directed: all-zero registers give a 3-tick scan back to back --
      write_reg(REG_SCAN_PERIOD, '0);
      write_reg(REG_DISCHARGE_TICKS, '0);
      write_reg(REG_CHARGE_TICKS, '0);
      write_reg(REG_UNUSED, 16'hFFFF);      // must not land anywhere
      queue_ticks(PIN_DIRECT, 12, 0);       // four positive scans -> positive
      queue_ticks(PIN_CAPACITOR, 12, 0);    // four negative scans -> negative
      drain();

      // -- directed: rewrite lengths while a scan is in its discharge phase;
      //    the running phase keeps its count, charge picks up the new value
      write_reg(REG_DISCHARGE_TICKS, 16'd5);
      write_reg(REG_CHARGE_TICKS, 16'd5);
      queue_ticks(PIN_RELEASED, 2, 0);
      drain();
      write_reg(REG_DISCHARGE_TICKS, '0);
      write_reg(REG_CHARGE_TICKS, '0);
      queue_ticks(PIN_RELEASED, 10, 0);
      drain();

      // -- random rounds: small register values so scans come often --
      random_ticks = 0;
      round = 0;
      while (random_ticks < 2000) begin
         gap_pct = (round % 5 == 3) ? 0 : 38;
         if ($urandom_range(9) == 0)
            write_reg(REG_UNUSED, 16'($urandom));
         if ($urandom_range(9) < 7) begin
            pick = $urandom_range(9);
            write_reg(REG_SCAN_PERIOD, (pick == 0) ? 16'd0 :
                      (pick == 1) ? 16'($urandom_range(20, 300)) :
                                    16'($urandom_range(1, 12)));
         end
         if ($urandom_range(9) < 7)
            write_reg(REG_DISCHARGE_TICKS, 16'($urandom_range(0, 6)));
         if ($urandom_range(9) < 7)
            write_reg(REG_CHARGE_TICKS, 16'($urandom_range(0, 6)));
         n = $urandom_range(40, 250);
         while (n > 0) begin
            seg  = $urandom_range(8, 60);
            seg  = (seg > n) ? n : seg;
            pick = $urandom_range(9);
            mode = (pick < 3) ? PIN_RELEASED : (pick < 5) ? PIN_DIRECT :
                   (pick < 8) ? PIN_CAPACITOR : PIN_NOISE;
            queue_ticks(mode, seg, 3);
            n            -= seg;
            random_ticks += seg;
         end
         drain();
         round++;
      end

      // -- extremes: the longest period keeps the sequencer idle, then a
      //    scan starts into a full-length discharge that holds the pin low
      gap_pct = 38;
      write_reg(REG_SCAN_PERIOD, COUNT_MAX);
      write_reg(REG_DISCHARGE_TICKS, '0);
      write_reg(REG_CHARGE_TICKS, '0);
      queue_ticks(PIN_DIRECT, 20, 0);
      drain();
      gap_pct = 0;
      write_reg(REG_SCAN_PERIOD, '0);
      write_reg(REG_DISCHARGE_TICKS, COUNT_MAX);
      write_reg(REG_CHARGE_TICKS, COUNT_MAX);
      queue_ticks(PIN_NOISE, 30, 0);
      drain();

      repeat (8) @(posedge clock);
      $display("Run covered %0d ticks, %0d scans and %0d register writes.",
               ticks_taken, scans_done, reg_writes);
      $display("Debounced direction in results: none %0d, positive %0d, negative %0d.",
               dir_seen[0], dir_seen[1], dir_seen[2]);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
